/* design/cfhs_pkg.sv */
// shared constants and codes for the color fade and hold sequencer
`timescale 1ns / 1ps

package cfhs_pkg;

  // table size default
  localparam int MAX_TARGETS_DEF = 8;

  // item kinds carried in s_tuser
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_WRITE   = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;
  localparam logic [1:0] FUNC_NONE    = 2'd3;

  // configuration register indexes
  localparam logic REG_NUM_TARGETS = 1'b0;
  localparam logic REG_FADE_LEN    = 1'b1;

  // register reset values
  localparam logic [3:0]  NUM_TARGETS_RST = 4'd2;
  localparam logic [15:0] FADE_LEN_RST    = 16'd100;

  // fixed field widths
  localparam int COLOR_W    = 16;
  localparam int ACC_W      = 32;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 56;

  // number of quotient bits per step computation
  localparam int DIV_STEPS = 32;

endpackage

/* design/color_fade_hold_sequencer.sv */
// top level of the color fade and hold sequencer
`timescale 1ns / 1ps

// usage
//   s_* : input beats; s_tuser selects tick, table write or restart,
//         s_tdata carries the table entry for a write
//   m_* : one result beat per tick with the color after that frame,
//         the stage after that frame and a refresh flag in m_tuser
//   cfg_* : register writes (targets in use, fade length), taken while idle
// state sequence per item
//   one item at a time; s_tready is high only while idle
//   tick in a hold stage: read the target entry, decide, present the result
//   plain fade frame: read the target entry, decide, accumulate, present the result
//   first frame of a fade (fade length nonzero): also forms the differences
//   and runs the bit-serial divider that forms the three per-frame steps
//   write or restart: read the last target and load the color, no result
// reset
//   control state, registers and the entry valid bits reset at once; an
//   entry never written reads as zero, so no clearing pass is needed
// stalls
//   a result waits in the output register; the next item is still taken,
//   and a following tick holds in its last step until the register frees

module color_fade_hold_sequencer #(
  parameter int MAX_TARGETS = cfhs_pkg::MAX_TARGETS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // entry_index[2:0], entry_l[18:3], entry_a[34:19], entry_b[50:35],
  // entry_hold[66:51], zero pad to 72
  input  logic [cfhs_pkg::IN_DATA_W-1:0]    s_tdata,
  // func[1:0]
  input  logic [1:0]                        s_tuser,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // color_l[15:0], color_a[31:16], color_b[47:32], stage_now[51:48], zero pad to 56
  output logic [cfhs_pkg::OUT_DATA_W-1:0]   m_tdata,
  // changed[0]
  output logic [0:0]                        m_tuser,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [15:0]                       cfg_data
);

  localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int STG_W = IDX_W + 1;
  localparam int CNT_W = $clog2(MAX_TARGETS + 1);
  localparam int LIM_W = CNT_W + 1;
  localparam int CW    = cfhs_pkg::COLOR_W;
  localparam int AW    = cfhs_pkg::ACC_W;
  localparam int ENT_W = 4 * CW;
  localparam int DCW   = $clog2(cfhs_pkg::DIV_STEPS);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TRD  = 4'd1;  // read the target entry
  localparam logic [3:0] S_TDEC = 4'd2;  // decide hold or fade, read the source entry
  localparam logic [3:0] S_TSRC = 4'd3;  // form differences, load the dividers
  localparam logic [3:0] S_DIV  = 4'd4;  // one quotient bit per cycle
  localparam logic [3:0] S_SAT  = 4'd5;  // sign and clamp the steps
  localparam logic [3:0] S_ADD  = 4'd6;  // accumulate one fade frame
  localparam logic [3:0] S_FIN  = 4'd7;  // advance stage, present result
  localparam logic [3:0] S_RRD  = 4'd8;  // restart: read the last target
  localparam logic [3:0] S_RLD  = 4'd9;  // restart: load the color

  logic [3:0] state;

  // configuration registers
  logic [3:0]  num_targets;
  logic [15:0] fade_len;

  // sequence position
  logic [STG_W-1:0] stage;
  logic [15:0]      frame_in_stage;
  logic [15:0]      stage_len;
  logic             dirty;

  // color accumulators and per-frame steps
  logic signed [AW-1:0] cur  [3];
  logic signed [AW-1:0] step [3];

  // divider lanes
  logic        [CW-1:0] dst  [3];
  logic        [AW-1:0] dv   [3];
  logic        [CW-1:0] rem  [3];
  logic        [AW-1:0] quo  [3];
  logic                 neg  [3];
  logic        [DCW-1:0] div_cnt;

  // target table memory, {hold, b, a, l}
  logic [ENT_W-1:0]       tbl [MAX_TARGETS];
  logic [MAX_TARGETS-1:0] ent_valid;
  logic [ENT_W-1:0]       mem_q;
  logic                   q_ok;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       wr_addr;
  logic                   wr_en;

  // decoded input fields
  logic [2:0]    in_index;
  logic [CW-1:0] in_l, in_a, in_b, in_hold;
  logic [IDX_W+2:0] idx_ext;

  // derived sequence values
  logic [CNT_W-1:0] count;
  logic [LIM_W-1:0] lim;
  logic [LIM_W-1:0] stage_ext;
  logic [IDX_W-1:0] last;
  logic [IDX_W-1:0] tgt;
  logic [IDX_W-1:0] src;
  logic [ENT_W-1:0] ent;
  logic [CW-1:0]    ent_c [3];
  logic [CW-1:0]    ent_hold;
  logic             in_acc;
  logic             stage_end;

  // datapath lanes
  logic [CW:0]          trial   [3];
  logic                 ge      [3];
  logic [CW:0]          trial_r [3];
  logic signed [CW:0]   diff    [3];
  logic [CW:0]          diff_abs[3];
  logic signed [AW-1:0] sat_q   [3];
  logic signed [AW:0]   sum     [3];
  logic signed [AW-1:0] sum_sat [3];

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign in_acc    = s_tvalid && s_tready;

  assign in_index = s_tdata[2:0];
  assign in_l     = s_tdata[18:3];
  assign in_a     = s_tdata[34:19];
  assign in_b     = s_tdata[50:35];
  assign in_hold  = s_tdata[66:51];
  assign idx_ext  = {{IDX_W{1'b0}}, in_index};
  assign wr_addr  = idx_ext[IDX_W-1:0];
  assign wr_en    = in_acc && (s_tuser == cfhs_pkg::FUNC_WRITE) &&
                    (32'(in_index) < MAX_TARGETS);

  // effective target count, clamped to 1..MAX_TARGETS
  always_comb begin
    if (num_targets == 4'd0) begin
      count = CNT_W'(1);
    end else if (32'(num_targets) > MAX_TARGETS) begin
      count = CNT_W'(MAX_TARGETS);
    end else begin
      count = CNT_W'(num_targets);
    end
  end

  assign lim       = {count, 1'b0};
  assign stage_ext = LIM_W'(stage);
  assign last      = IDX_W'(count - CNT_W'(1));
  assign tgt       = stage[STG_W-1:1];
  assign src       = (tgt == '0) ? last : tgt - IDX_W'(1);
  assign stage_end = (stage_len == 16'd0) || (frame_in_stage >= stage_len - 16'd1);

  always_comb begin
    case (state)
      S_TRD:   rd_addr = tgt;
      S_TDEC:  rd_addr = src;
      S_RRD:   rd_addr = last;
      default: rd_addr = tgt;
    endcase
  end

  // unwritten entries read as zero
  assign ent      = q_ok ? mem_q : '0;
  assign ent_c[0] = ent[CW-1:0];
  assign ent_c[1] = ent[2*CW-1:CW];
  assign ent_c[2] = ent[3*CW-1:2*CW];
  assign ent_hold = ent[4*CW-1:3*CW];

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl[wr_addr] <= {in_hold, in_b, in_a, in_l};
    end
    mem_q <= tbl[rd_addr];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // restoring division step, remainder stays below the fade length
      trial[i]   = {rem[i], dv[i][AW-1]};
      ge[i]      = (trial[i] >= {1'b0, fade_len});
      trial_r[i] = trial[i] - {1'b0, fade_len};
      // target minus previous target, magnitude fits in 16 bits
      diff[i]     = $signed({dst[i][CW-1], dst[i]}) - $signed({ent_c[i][CW-1], ent_c[i]});
      diff_abs[i] = diff[i][CW] ? (CW+1)'(-diff[i]) : (CW+1)'(diff[i]);
      // signed quotient clamped to the 32-bit range
      if (!neg[i]) begin
        sat_q[i] = quo[i][AW-1] ? {1'b0, {(AW-1){1'b1}}} : $signed(quo[i]);
      end else if (quo[i] > {1'b1, {(AW-1){1'b0}}}) begin
        sat_q[i] = {1'b1, {(AW-1){1'b0}}};
      end else begin
        sat_q[i] = $signed(-quo[i]);
      end
      // saturating accumulate
      sum[i] = {cur[i][AW-1], cur[i]} + {step[i][AW-1], step[i]};
      if (sum[i][AW] != sum[i][AW-1]) begin
        sum_sat[i] = sum[i][AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
      end else begin
        sum_sat[i] = sum[i][AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      num_targets    <= cfhs_pkg::NUM_TARGETS_RST;
      fade_len       <= cfhs_pkg::FADE_LEN_RST;
      stage          <= '0;
      frame_in_stage <= '0;
      ent_valid      <= '0;
      q_ok           <= 1'b0;
      m_tvalid       <= 1'b0;
      dirty          <= 1'b0;
      div_cnt        <= '0;
      for (int i = 0; i < 3; i++) begin
        cur[i]  <= '0;
        step[i] <= '0;
      end
    end else begin
      q_ok <= ent_valid[rd_addr];
      if (wr_en) begin
        ent_valid[wr_addr] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cfhs_pkg::REG_NUM_TARGETS) begin
          num_targets <= cfg_data[3:0];
        end else begin
          fade_len <= cfg_data;
        end
      end
      // result valid: raised when a tick finishes, dropped once taken
      if (state == S_FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (s_tuser)
              cfhs_pkg::FUNC_TICK: begin
                // count was lowered below the current stage
                if (stage_ext >= lim) begin
                  stage          <= '0;
                  frame_in_stage <= '0;
                end
                state <= S_TRD;
              end
              cfhs_pkg::FUNC_WRITE, cfhs_pkg::FUNC_RESTART: begin
                stage          <= '0;
                frame_in_stage <= '0;
                state          <= S_RRD;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_TRD: begin
          state <= S_TDEC;
        end
        S_TDEC: begin
          if (stage[0]) begin
            // hold stage: first frame snaps to the exact target
            if (frame_in_stage == 16'd0) begin
              for (int i = 0; i < 3; i++) begin
                cur[i] <= {ent_c[i], 16'h0000};
              end
              dirty <= 1'b1;
            end else begin
              dirty <= 1'b0;
            end
            stage_len <= ent_hold;
            state     <= S_FIN;
          end else begin
            stage_len <= fade_len;
            if (frame_in_stage == 16'd0 && fade_len != 16'd0) begin
              for (int i = 0; i < 3; i++) begin
                dst[i] <= ent_c[i];
              end
              state <= S_TSRC;
            end else begin
              state <= S_ADD;
            end
          end
        end
        S_TSRC: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= diff[i][CW];
            dv[i]  <= {diff_abs[i][CW-1:0], 16'h0000};
            rem[i] <= '0;
            quo[i] <= '0;
          end
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          for (int i = 0; i < 3; i++) begin
            rem[i] <= ge[i] ? trial_r[i][CW-1:0] : trial[i][CW-1:0];
            quo[i] <= {quo[i][AW-2:0], ge[i]};
            dv[i]  <= {dv[i][AW-2:0], 1'b0};
          end
          div_cnt <= div_cnt + DCW'(1);
          if (div_cnt == DCW'(cfhs_pkg::DIV_STEPS - 1)) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          for (int i = 0; i < 3; i++) begin
            step[i] <= sat_q[i];
          end
          state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 3; i++) begin
            cur[i] <= sum_sat[i];
          end
          dirty <= 1'b1;
          state <= S_FIN;
        end
        S_FIN: begin
          // wait here while an older result is still unread
          if (!m_tvalid || m_tready) begin
            if (stage_end) begin
              stage          <= (stage_ext + LIM_W'(1) == lim) ? '0 : stage + STG_W'(1);
              frame_in_stage <= '0;
            end else begin
              frame_in_stage <= frame_in_stage + 16'd1;
            end
            state <= S_IDLE;
          end
        end
        S_RRD: begin
          state <= S_RLD;
        end
        S_RLD: begin
          for (int i = 0; i < 3; i++) begin
            cur[i] <= {ent_c[i], 16'h0000};
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload, stage reported after advancing
  logic [STG_W-1:0] stage_after;
  assign stage_after = stage_end ?
                       ((stage_ext + LIM_W'(1) == lim) ? '0 : stage + STG_W'(1)) : stage;

  logic [STG_W+3:0] stage_after_ext;
  assign stage_after_ext = {4'd0, stage_after};

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!m_tvalid || m_tready)) begin
      m_tdata <= {4'd0, stage_after_ext[3:0], cur[2][AW-1:CW], cur[1][AW-1:CW],
                  cur[0][AW-1:CW]};
      m_tuser <= dirty;
    end
  end

endmodule

/* design/cfhs_checker.sv */
// port-level checks for the color fade and hold sequencer, bound to the top level
`timescale 1ns / 1ps

module cfhs_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [1:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic       cfg_ready
);

  // no result beat right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  // a pending result beat is not withdrawn
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  // a tick keeps the block busy on the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == cfhs_pkg::FUNC_TICK |=> !s_tready && !cfg_ready)
    else $error("block free right after a tick");

  // writes, restarts and unused kinds never produce a result beat
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != cfhs_pkg::FUNC_TICK && !m_tvalid |=> !m_tvalid)
    else $error("result beat from a non-tick item");

endmodule

bind color_fade_hold_sequencer cfhs_checker u_cfhs_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tuser   (s_tuser),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .cfg_ready (cfg_ready)
);

/* sim/color_fade_hold_sequencer_tb.sv */
// self-checking testbench for the color fade and hold sequencer
`timescale 1ns / 1ps

module color_fade_hold_sequencer_tb;

  // idle cycles with no handshake at all before the run is declared hung;
  // the longest legal gap is the sink hold-off plus one fade start
  localparam int HANG_LIMIT = 2000;
  // quiet cycles before a register write, covers a fade start plus margin
  localparam int SETTLE_CYCLES = 60;
  // length of the one long sink hold-off
  localparam int BACKPRESSURE_CYCLES = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int BEATS_PER_PHASE = 86;

  // one input beat, fields as the block sees them
  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  idx;
    logic [15:0] l;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] hold;
  } entry_item_t;

  // one result beat
  typedef struct packed {
    logic [15:0] l;
    logic [15:0] a;
    logic [15:0] b;
    logic        changed;
    logic [3:0]  stg;
  } color_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [cfhs_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]                      s_tuser = cfhs_pkg::FUNC_TICK;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [cfhs_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [0:0]                      m_tuser;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic                            cfg_index = cfhs_pkg::REG_NUM_TARGETS;
  logic [15:0]                     cfg_data = '0;

  color_fade_hold_sequencer #(
    .MAX_TARGETS(cfhs_pkg::MAX_TARGETS_DEF)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // beats waiting to be offered, and colors predicted but not yet seen
  entry_item_t   beat_q[$];
  color_result_t pending_colors[$];
  entry_item_t   offered;

  // shadow of the sequencer state
  logic signed [15:0] tab_col [0:cfhs_pkg::MAX_TARGETS_DEF-1][0:2];
  logic [15:0]        tab_hold [0:cfhs_pkg::MAX_TARGETS_DEF-1];
  logic signed [31:0] acc [0:2];
  logic signed [31:0] stp [0:2];
  int unsigned        stg;
  int unsigned        frm;
  logic [3:0]         cnt_reg = cfhs_pkg::NUM_TARGETS_RST;
  logic [15:0]        fade_reg = cfhs_pkg::FADE_LEN_RST;

  // run control
  logic          calm = 1'b0;
  int            errors = 0;
  int            results_seen = 0;
  int            hold_left = 0;
  logic          hold_done = 1'b0;
  int            hang_count = 0;
  color_result_t got_res;
  color_result_t want_res;

  initial begin
    for (int i = 0; i < cfhs_pkg::MAX_TARGETS_DEF; i++) begin
      for (int c = 0; c < 3; c++) tab_col[i][c] = '0;
      tab_hold[i] = '0;
    end
    for (int c = 0; c < 3; c++) begin
      acc[c] = '0;
      stp[c] = '0;
    end
    stg = 0;
    frm = 0;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // per-frame increment in Q16.16: difference of the signed 16-bit colors widened by 16 fraction bits,
  // divided by the frame count with truncation toward zero
  function automatic logic signed [31:0] fade_step(input logic signed [15:0] dst,
                                                   input logic signed [15:0] src);
    longint num;
    num = (longint'(dst) - longint'(src)) * 64'sd65536;
    return clamp32(num / longint'(fade_reg));
  endfunction

  // target count as the block uses it, clamped to 1..table size
  function automatic int unsigned live_targets();
    if (cnt_reg == 0) return 1;
    if (cnt_reg > cfhs_pkg::MAX_TARGETS_DEF) return cfhs_pkg::MAX_TARGETS_DEF;
    return cnt_reg;
  endfunction

  // back to the first fade, color jumps to the last target in use
  function automatic void restart_sequence();
    int unsigned last;
    last = live_targets() - 1;
    stg = 0;
    frm = 0;
    for (int c = 0; c < 3; c++) acc[c] = {tab_col[last][c], 16'h0000};
  endfunction

  // apply one accepted beat to the shadow state; a tick queues its color
  function automatic void predict_frame(input entry_item_t it);
    color_result_t r;
    int unsigned   ec;
    int unsigned   t;
    int unsigned   src;
    int unsigned   frames;
    logic          dirty;
    if (it.func == cfhs_pkg::FUNC_WRITE) begin
      tab_col[it.idx][0] = it.l;
      tab_col[it.idx][1] = it.a;
      tab_col[it.idx][2] = it.b;
      tab_hold[it.idx]   = it.hold;
      restart_sequence();
    end else if (it.func == cfhs_pkg::FUNC_RESTART) begin
      restart_sequence();
    end else if (it.func == cfhs_pkg::FUNC_TICK) begin
      ec = live_targets();
      dirty = 1'b0;
      // target count lowered under the current stage
      if (stg >= 2 * ec) begin
        stg = 0;
        frm = 0;
      end
      t = stg / 2;
      if (stg % 2 == 1) begin
        // hold: the first frame snaps to the exact target
        if (frm == 0) begin
          for (int c = 0; c < 3; c++) acc[c] = {tab_col[t][c], 16'h0000};
          dirty = 1'b1;
        end
        frames = tab_hold[t];
      end else begin
        // fade: steps are formed on the first frame, kept when count is zero
        if (frm == 0 && fade_reg != 0) begin
          src = (t == 0) ? ec - 1 : t - 1;
          for (int c = 0; c < 3; c++) stp[c] = fade_step(tab_col[t][c], tab_col[src][c]);
        end
        frames = fade_reg;
        for (int c = 0; c < 3; c++) acc[c] = clamp32(longint'(acc[c]) + longint'(stp[c]));
        dirty = 1'b1;
      end
      // a lowered count ends the stage at once
      if (frames == 0 || frm >= frames - 1) begin
        stg = (stg + 1) % (2 * ec);
        frm = 0;
      end else begin
        frm = (frm + 1) & 32'hffff;
      end
      r.l = acc[0][31:16];
      r.a = acc[1][31:16];
      r.b = acc[2][31:16];
      r.changed = dirty;
      r.stg = stg[3:0];
      pending_colors.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  function automatic logic [15:0] rand_color();
    case ($urandom_range(9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_hold();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(4));
    if (r < 90) return 16'($urandom_range(5, 40));
    if (r < 95) return 16'hffff;
    return 16'($urandom);
  endfunction

  function automatic entry_item_t make_beat(input logic [1:0] func, input logic [2:0] idx,
                                            input logic [15:0] l, input logic [15:0] a,
                                            input logic [15:0] b, input logic [15:0] hold);
    entry_item_t it;
    it.func = func;
    it.idx  = idx;
    it.l    = l;
    it.a    = a;
    it.b    = b;
    it.hold = hold;
    return it;
  endfunction

  // mostly ticks; table writes, restarts and the unused kind mixed in.
  // ticks carry random payload too, which the block must ignore
  function automatic entry_item_t rand_beat();
    entry_item_t it;
    int unsigned r;
    it = make_beat(cfhs_pkg::FUNC_TICK, 3'($urandom_range(7)), rand_color(), rand_color(),
                   rand_color(), rand_hold());
    r = $urandom_range(99);
    if (r < 10) it.func = cfhs_pkg::FUNC_WRITE;
    else if (r < 14) it.func = cfhs_pkg::FUNC_RESTART;
    else if (r < 17) it.func = cfhs_pkg::FUNC_NONE;
    return it;
  endfunction

  function automatic void push_ticks(input int n);
    for (int i = 0; i < n; i++)
      beat_q.push_back(make_beat(cfhs_pkg::FUNC_TICK, 3'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom)));
  endfunction

  // wait until every beat is taken and every color has come back,
  // then let a fade start or a write finish inside the block
  task automatic wait_idle();
    while (beat_q.size() != 0 || s_tvalid || pending_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == cfhs_pkg::REG_NUM_TARGETS) cnt_reg = val[3:0];
    else fade_reg = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
    $display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
    errors++;
  endtask

  // ---------------------------------------------------------------------
  // driver: offers queued beats, idles at random between beats
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_frame(offered);
      // one assignment to s_tvalid per edge; a held beat stays untouched
      if (!s_tvalid || s_tready) begin
        if (beat_q.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
          offered = beat_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= offered.func;
          s_tdata  <= {5'b0, offered.hold, offered.b, offered.a, offered.l, offered.idx};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: checks result beats, random sink stalls, one long hold-off
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_res.l       = m_tdata[15:0];
        got_res.a       = m_tdata[31:16];
        got_res.b       = m_tdata[47:32];
        got_res.stg     = m_tdata[51:48];
        got_res.changed = m_tuser[0];
        if (pending_colors.size() == 0) begin
          report("result beat with none pending", 16'h0, got_res.l);
        end else begin
          want_res = pending_colors.pop_front();
          if (got_res.l !== want_res.l) report("color_l", want_res.l, got_res.l);
          if (got_res.a !== want_res.a) report("color_a", want_res.a, got_res.a);
          if (got_res.b !== want_res.b) report("color_b", want_res.b, got_res.b);
          if (got_res.changed !== want_res.changed)
            report("changed", 16'(want_res.changed), 16'(got_res.changed));
          if (got_res.stg !== want_res.stg)
            report("stage_now", 16'(want_res.stg), 16'(got_res.stg));
        end
        results_seen++;
      end
      // the long hold-off lets the block fill up and push back on the sender
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 150) begin
        hold_done = 1'b1;
        hold_left = BACKPRESSURE_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || $urandom_range(99) >= 16;
      end
    end
  end

  // hang detection: no beat on any channel for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        hang_count <= 0;
      else
        hang_count <= hang_count + 1;
      if (hang_count >= HANG_LIMIT) begin
        $display("%0t no progress, %0d colors outstanding", $realtime, pending_colors.size());
        $display("color_fade_hold_sequencer_tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // sequence of phases
  // ---------------------------------------------------------------------
  initial begin
    logic [3:0]  cnt;
    logic [15:0] ff;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extreme entries, single-frame fades so the steps saturate
    write_cfg(cfhs_pkg::REG_NUM_TARGETS, 16'h0002);
    write_cfg(cfhs_pkg::REG_FADE_LEN, 16'h0001);
    beat_q.push_back(make_beat(cfhs_pkg::FUNC_WRITE, 3'd0, 16'h7fff, 16'h8000, 16'h0000,
                               16'h0000));
    beat_q.push_back(make_beat(cfhs_pkg::FUNC_WRITE, 3'd1, 16'h8000, 16'h7fff, 16'hffff,
                               16'h0001));
    push_ticks(5);
    beat_q.push_back(make_beat(cfhs_pkg::FUNC_NONE, 3'd7, 16'hffff, 16'hffff, 16'hffff,
                               16'hffff));
    beat_q.push_back(make_beat(cfhs_pkg::FUNC_RESTART, 3'd5, 16'h1234, 16'h5678, 16'h9abc,
                               16'hdef0));
    push_ticks(2);
    wait_idle();

    // zero fade length: earlier steps stay, stages end at once
    write_cfg(cfhs_pkg::REG_FADE_LEN, 16'h0000);
    push_ticks(3);
    wait_idle();

    // full table, upper register bits set, walk a few stages forward
    write_cfg(cfhs_pkg::REG_NUM_TARGETS, 16'hfff8);
    write_cfg(cfhs_pkg::REG_FADE_LEN, 16'h0001);
    beat_q.push_back(make_beat(cfhs_pkg::FUNC_WRITE, 3'd7, 16'h0001, 16'hfffe, 16'h4000,
                               16'h0002));
    push_ticks(5);
    wait_idle();

    // one target only: the stage is now out of range and wraps to zero
    write_cfg(cfhs_pkg::REG_NUM_TARGETS, 16'h0001);
    push_ticks(2);
    wait_idle();

    // count of zero clamps up, longest fade leaves the stage midway
    write_cfg(cfhs_pkg::REG_NUM_TARGETS, 16'h0000);
    write_cfg(cfhs_pkg::REG_FADE_LEN, 16'hffff);
    push_ticks(3);
    wait_idle();

    // count above the table clamps down, shorter fade ends the stage at once
    write_cfg(cfhs_pkg::REG_NUM_TARGETS, 16'h000f);
    write_cfg(cfhs_pkg::REG_FADE_LEN, 16'h0002);
    push_ticks(2);
    wait_idle();

    // random phases, the first without any idling on either side
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      cnt = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
      case ($urandom_range(9))
        0:       ff = 16'h0000;
        1:       ff = 16'h0001;
        2:       ff = 16'hffff;
        3:       ff = 16'($urandom);
        default: ff = 16'($urandom_range(2, 12));
      endcase
      write_cfg(cfhs_pkg::REG_NUM_TARGETS, {12'($urandom), cnt});
      write_cfg(cfhs_pkg::REG_FADE_LEN, ff);
      calm = (p == 0);
      for (int i = 0; i < BEATS_PER_PHASE; i++) beat_q.push_back(rand_beat());
      wait_idle();
    end

    if (errors == 0) begin
      $display("color_fade_hold_sequencer_tb OK");
    end else begin
      $display("color_fade_hold_sequencer_tb NOT OK");
    end
    $finish;
  end

endmodule

/* color_fade_hold_sequencer.f */
design/cfhs_pkg.sv
design/color_fade_hold_sequencer.sv
design/cfhs_checker.sv
sim/color_fade_hold_sequencer_tb.sv
